// File: rtl/lvps_pkg.sv
// Shared types and constants for the latching valve pulse sequencer.
`default_nettype none

package lvps_pkg;

	// Number of driven valves (1..8); drive and mask fields stay 8 bits wide
	localparam int NUM_VALVES = 8;
	localparam int VIDX_W     = (NUM_VALVES > 1) ? $clog2(NUM_VALVES) : 1;
	localparam int LINE_W     = 8;
	localparam int PERIOD_W   = 16;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
	localparam logic [PERIOD_W-1:0] ELAPSED_MAX  = 16'hFFFF;
	localparam logic [VIDX_W-1:0]   LAST_VALVE   = VIDX_W'(NUM_VALVES - 1);

	// Per-valve state code
	typedef enum logic [1:0] {
		VS_UNKNOWN = 2'd0,
		VS_OPEN    = 2'd1,
		VS_CLOSED  = 2'd2
	} valve_state_t;

	// Input transaction kind
	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_SET  = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [7:0]  valve_index;
		logic        open_request;
	} item_t;

	typedef struct packed {
		logic [LINE_W-1:0] open_mask;
		logic              pulse_active;
		logic [LINE_W-1:0] drive_b;
		logic [LINE_W-1:0] drive_a;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/lvps_in_stage.sv
// Input register stage with stream handshake for the valve pulse sequencer.
`default_nettype none

module lvps_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire lvps_pkg::item_t in_item,
	input  wire logic          down_ready,
	output logic               advance,
	output lvps_pkg::item_t    item_s1
);

	logic valid_s1;

	// Move the held transaction on when the result register can take it
	assign advance  = valid_s1 && down_ready;
	assign in_ready = !valid_s1 || down_ready;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// File: rtl/lvps_core.sv
// Valve state, millisecond counter and drive update logic.
`default_nettype none

module lvps_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [lvps_pkg::PERIOD_W-1:0] cfg_wdata,
	input  wire logic                          advance,
	input  wire lvps_pkg::item_t               item_s1,
	output lvps_pkg::result_t                  result
);

	logic [lvps_pkg::PERIOD_W-1:0] period_q;
	logic [lvps_pkg::PERIOD_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	lvps_pkg::valve_state_t        req_q [lvps_pkg::NUM_VALVES];
	lvps_pkg::valve_state_t        req_d [lvps_pkg::NUM_VALVES];
	lvps_pkg::valve_state_t        act_q [lvps_pkg::NUM_VALVES];
	lvps_pkg::valve_state_t        act_d [lvps_pkg::NUM_VALVES];
	logic [lvps_pkg::LINE_W-1:0]   a_q, a_d, b_q, b_d, mask_d;
	logic                          pulsing_q, pulsing_d;
	logic [lvps_pkg::VIDX_W-1:0]   idx_sat, sel;
	logic                          found, fire;

	// Saturate the valve index to the last valve
	always_comb begin
		if (item_s1.valve_index > 8'(lvps_pkg::NUM_VALVES - 1)) begin
			idx_sat = lvps_pkg::LAST_VALVE;
		end else begin
			idx_sat = item_s1.valve_index[lvps_pkg::VIDX_W-1:0];
		end
	end

	// Advance the millisecond count, saturating at the top
	assign elapsed_inc = (elapsed_q == lvps_pkg::ELAPSED_MAX) ? elapsed_q
	                                                          : elapsed_q + 16'd1;
	assign fire = (item_s1.kind == lvps_pkg::KIND_TICK) && (elapsed_inc >= period_q);

	// Find the lowest valve whose known request differs from its actual state
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int i = 0; i < lvps_pkg::NUM_VALVES; i++) begin
			if (!found && req_q[i] != lvps_pkg::VS_UNKNOWN && req_q[i] != act_q[i]) begin
				found = 1'b1;
				sel   = lvps_pkg::VIDX_W'(i);
			end
		end
	end

	// Next state for one transaction
	always_comb begin
		req_d     = req_q;
		act_d     = act_q;
		elapsed_d = elapsed_q;
		a_d       = a_q;
		b_d       = b_q;
		pulsing_d = pulsing_q;
		if (item_s1.kind == lvps_pkg::KIND_SET) begin
			req_d[idx_sat] = item_s1.open_request ? lvps_pkg::VS_OPEN : lvps_pkg::VS_CLOSED;
		end else if (fire) begin
			elapsed_d = '0;
			a_d       = '0;
			b_d       = '0;
			pulsing_d = found;
			if (found) begin
				act_d[sel] = req_q[sel];
				if (req_q[sel] == lvps_pkg::VS_OPEN) begin
					a_d[sel] = 1'b1;
				end else begin
					b_d[sel] = 1'b1;
				end
			end
		end else begin
			elapsed_d = elapsed_inc;
		end
	end

	// Build the open mask from the updated actual states
	always_comb begin
		mask_d = '0;
		for (int i = 0; i < lvps_pkg::NUM_VALVES; i++) begin
			mask_d[i] = (act_d[i] == lvps_pkg::VS_OPEN);
		end
	end

	assign result.drive_a      = a_d;
	assign result.drive_b      = b_d;
	assign result.pulse_active = pulsing_d;
	assign result.open_mask    = mask_d;

	// Hold the change period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= lvps_pkg::PERIOD_RESET;
		end else if (cfg_wen) begin
			period_q <= cfg_wdata;
		end
	end

	// Commit state when a transaction moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			a_q       <= '0;
			b_q       <= '0;
			pulsing_q <= 1'b0;
			for (int i = 0; i < lvps_pkg::NUM_VALVES; i++) begin
				req_q[i] <= lvps_pkg::VS_UNKNOWN;
				act_q[i] <= lvps_pkg::VS_UNKNOWN;
			end
		end else if (advance) begin
			elapsed_q <= elapsed_d;
			a_q       <= a_d;
			b_q       <= b_d;
			pulsing_q <= pulsing_d;
			req_q     <= req_d;
			act_q     <= act_d;
		end
	end

	// At most one drive line is high across both sides
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0({a_q, b_q}))
		else $error("more than one drive line active");

	// The pulse flag matches the drive lines
	assert property (@(posedge clk) disable iff (!arst_n) pulsing_q == |(a_q | b_q))
		else $error("pulse flag disagrees with drive lines");

	// An update restarts the count
	assert property (@(posedge clk) disable iff (!arst_n) advance && fire |=> elapsed_q == '0)
		else $error("count not restarted on update");

	// A set command leaves count and lines alone
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.kind == lvps_pkg::KIND_SET |=> $stable(elapsed_q) && $stable(a_q)
			&& $stable(b_q))
		else $error("set command disturbed count or lines");

endmodule

`default_nettype wire

// File: rtl/latching_valve_pulse_sequencer_unit.sv
// Top level of the latching valve pulse sequencer: ports and result register.
`default_nettype none

// Drives up to eight latching valves through per-valve A (open) and B (close)
// lines. Every input transaction, tick or set command, yields exactly one result
// transaction carrying the drive lines, the pulse flag and the open-valve mask.
// One transaction is accepted per clock while no result waits on m_axis_tready.
// It is held in the input register, and its result is loaded into the result
// register when that register can take it; the state update between the two
// registers is combinational. A result waiting on m_axis_tready stalls the
// input register: one more transaction is accepted while that register is
// empty, then s_axis_tready drops until the result is taken. Write
// change_period only while idle.
module latching_valve_pulse_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [7:0] valve_index, [8] open_request
	input  wire logic        s_axis_tuser,  // [0] kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata   // [7:0] drive_a, [15:8] drive_b,
	                                        // [16] pulse_active, [24:17] open_mask
);

	lvps_pkg::item_t   in_item, item_s1;
	lvps_pkg::result_t result, result_s2;
	logic              down_ready, advance;

	// Unpack the input transaction
	assign in_item.kind         = lvps_pkg::item_kind_t'(s_axis_tuser);
	assign in_item.valve_index  = s_axis_tdata[7:0];
	assign in_item.open_request = s_axis_tdata[8];

	assign down_ready = !m_axis_tvalid || m_axis_tready;

	lvps_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_item    (in_item),
		.down_ready (down_ready),
		.advance    (advance),
		.item_s1    (item_s1)
	);

	lvps_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.item_s1   (item_s1),
		.result    (result)
	);

	// Hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (down_ready) begin
			m_axis_tvalid <= advance;
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	// Pack the result transaction
	assign m_axis_tdata = {7'd0, result_s2.open_mask, result_s2.pulse_active,
	                       result_s2.drive_b, result_s2.drive_a};

endmodule

`default_nettype wire
